// File: rtl/csb_pkg.sv
// Shared types and codes for the counting semaphore bank.
package csb_pkg;

	localparam logic [1:0] OP_CREATE = 2'd0;
	localparam logic [1:0] OP_WAIT   = 2'd1;
	localparam logic [1:0] OP_POST   = 2'd2;
	localparam logic [1:0] OP_REMOVE = 2'd3;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BLOCKED   = 3'd1;
	localparam logic [2:0] ST_EXISTS    = 3'd2;
	localparam logic [2:0] ST_NOT_OPEN  = 3'd3;
	localparam logic [2:0] ST_FULL      = 3'd4;
	localparam logic [2:0] ST_NOT_FOUND = 3'd5;

	typedef struct packed {
		logic [1:0]  operation;
		logic [2:0]  sem_index;
		logic [15:0] proc_id;
		logic [31:0] init_count;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        woken_valid;
		logic [15:0] woken_pid;
		logic [31:0] count_after;
	} rsp_t;

endpackage

// File: rtl/csb_queue_mem.sv
// Wait queue storage: one synchronous memory of pids, one read and one write port.
module csb_queue_mem #(
	parameter int AW = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [15:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [15:0]   rdata
);

	logic [15:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/counting_semaphore_bank.sv
// Counting semaphore bank: per-slot count and FIFO wait queue of pids.
// Create, wait, plain post and misses go from the first step straight to done;
// a post that wakes a waiter and a remove with a non-empty queue also walk the queue.
// Remove checks one entry at a time through the READ and SCAN states, then compacts one entry per cycle.
// busy covers the item through its done cycle, so the next beat is taken in the cycle after done.
// The receiver cannot stall; arst_n clears all slots, the queue memory needs no clearing.
module counting_semaphore_bank #(
	parameter int NUM_SEMS    = 8,
	parameter int QUEUE_DEPTH = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  csb_pkg::cmd_t cmd,
	output logic          busy,
	output logic          done,
	output csb_pkg::rsp_t rsp
);

	localparam int SW = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
	localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int NW = $clog2(QUEUE_DEPTH + 1);
	localparam int AW = SW + QW;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_READ = 3'd2;
	localparam logic [2:0] S_SCAN = 3'd3;
	localparam logic [2:0] S_SHFT = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0]         state_q;
	csb_pkg::cmd_t      cmd_q;
	logic [SW-1:0]      sl_q;
	logic               in_use_q [NUM_SEMS];
	logic [31:0]        count_q  [NUM_SEMS];
	logic [NW-1:0]      total_q  [NUM_SEMS];
	logic [QW-1:0]      pos_q;
	logic               found_q;
	csb_pkg::rsp_t      rsp_q;

	logic               we;
	logic [QW-1:0]      wpos;
	logic [15:0]        wdata;
	logic [QW-1:0]      rpos;
	logic [15:0]        rdata;

	logic               range_ok;
	logic [NW-1:0]      n;
	logic [31:0]        cnt;
	logic               nxt_last;

	csb_pkg::rsp_t      exec_rsp;
	logic [2:0]         exec_nxt;
	logic               exec_wake;

	assign range_ok = ({24'd0, cmd_q.sem_index} < 27'(NUM_SEMS));
	assign n        = total_q[sl_q];
	assign cnt      = count_q[sl_q];
	assign nxt_last = (NW'(pos_q) + NW'(1) >= n);

	csb_queue_mem #(.AW(AW)) u_mem (
		.clk   (clk),
		.we    (we),
		.waddr ({sl_q, wpos}),
		.wdata (wdata),
		.raddr ({sl_q, rpos}),
		.rdata (rdata)
	);

	// Memory ports: append on a blocking wait, compaction during shift, and the read address.
	always_comb begin
		we    = 1'b0;
		wpos  = QW'(n);
		wdata = cmd_q.proc_id;
		rpos  = pos_q;
		if (state_q == S_EXEC && cmd_q.operation == csb_pkg::OP_WAIT && range_ok
				&& in_use_q[sl_q] && cnt == 32'd0 && n < NW'(QUEUE_DEPTH)) begin
			we = 1'b1;
		end
		if (state_q == S_SHFT) begin
			// rdata holds entry pos+1, move it down to pos.
			we    = !nxt_last;
			wpos  = pos_q;
			wdata = rdata;
			rpos  = QW'(NW'(pos_q) + NW'(2));
		end
		if (state_q == S_SCAN || state_q == S_READ) begin
			rpos = QW'(NW'(pos_q) + NW'(1));
		end
		if (state_q == S_EXEC) begin
			rpos = '0;
		end
	end

	// Outcome of the first step of an operation.
	always_comb begin
		exec_rsp  = '0;
		exec_nxt  = S_DONE;
		exec_wake = 1'b0;
		if (!range_ok) begin
			exec_rsp.status = csb_pkg::ST_NOT_OPEN;
		end else if (cmd_q.operation == csb_pkg::OP_CREATE) begin
			if (in_use_q[sl_q]) begin
				exec_rsp.status      = csb_pkg::ST_EXISTS;
				exec_rsp.count_after = cnt;
			end else begin
				exec_rsp.count_after = cmd_q.init_count;
			end
		end else if (!in_use_q[sl_q]) begin
			exec_rsp.status = csb_pkg::ST_NOT_OPEN;
		end else begin
			exec_rsp.count_after = cnt;
			unique case (cmd_q.operation)
				csb_pkg::OP_WAIT: begin
					if (cnt != 32'd0) begin
						exec_rsp.count_after = cnt - 32'd1;
					end else if (n >= NW'(QUEUE_DEPTH)) begin
						exec_rsp.status = csb_pkg::ST_FULL;
					end else begin
						exec_rsp.status = csb_pkg::ST_BLOCKED;
					end
				end
				csb_pkg::OP_POST: begin
					if (cnt != 32'd0 || n == '0) begin
						if (cnt != 32'hFFFF_FFFF) begin
							exec_rsp.count_after = cnt + 32'd1;
						end
					end else begin
						exec_wake = 1'b1;
						exec_nxt  = S_READ;
					end
				end
				default: begin
					if (n == '0) begin
						exec_rsp.status = csb_pkg::ST_NOT_FOUND;
					end else begin
						exec_nxt = S_READ;
					end
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);
	assign rsp  = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cmd_q   <= '0;
			sl_q    <= '0;
			pos_q   <= '0;
			found_q <= 1'b0;
			rsp_q   <= '0;
			for (int i = 0; i < NUM_SEMS; i++) begin
				in_use_q[i] <= 1'b0;
				count_q[i]  <= '0;
				total_q[i]  <= '0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q   <= cmd;
						sl_q    <= SW'(cmd.sem_index);
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					rsp_q   <= exec_rsp;
					pos_q   <= '0;
					found_q <= exec_wake;
					state_q <= exec_nxt;
					// A fresh create opens the slot; any other operation needs it open.
					if (range_ok && ((cmd_q.operation == csb_pkg::OP_CREATE)
							!= in_use_q[sl_q])) begin
						in_use_q[sl_q] <= 1'b1;
						count_q[sl_q]  <= exec_rsp.count_after;
					end
					if (exec_rsp.status == csb_pkg::ST_BLOCKED) begin
						total_q[sl_q] <= n + NW'(1);
					end else if (range_ok && cmd_q.operation == csb_pkg::OP_CREATE
							&& !in_use_q[sl_q]) begin
						total_q[sl_q] <= '0;
					end
				end
				S_READ: begin
					// rdata now holds entry pos.
					if (found_q) begin
						rsp_q.woken_valid <= 1'b1;
						rsp_q.woken_pid   <= rdata;
					end
					if (found_q || rdata == cmd_q.proc_id) begin
						found_q <= 1'b1;
						if (nxt_last) begin
							total_q[sl_q] <= n - NW'(1);
							state_q       <= S_DONE;
						end else begin
							state_q <= S_SHFT;
						end
					end else if (nxt_last) begin
						rsp_q.status <= csb_pkg::ST_NOT_FOUND;
						state_q      <= S_DONE;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					// Fetch entry pos+1 and look at it next cycle.
					pos_q   <= QW'(NW'(pos_q) + NW'(1));
					state_q <= S_READ;
				end
				S_SHFT: begin
					if (nxt_last) begin
						total_q[sl_q] <= n - NW'(1);
						state_q       <= S_DONE;
					end else begin
						pos_q <= QW'(NW'(pos_q) + NW'(1));
					end
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: bench/tb.sv
// Self-checking testbench for the counting semaphore bank.
`timescale 1ns / 100ps

module tb;

	localparam int NSEM  = 8;
	localparam int QDEP  = 8;
	localparam int NRAND = 1900;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           start = 1'b0;
	csb_pkg::cmd_t  cmd = '0;
	logic           busy, done;
	csb_pkg::rsp_t  rsp;

	counting_semaphore_bank #(.NUM_SEMS(NSEM), .QUEUE_DEPTH(QDEP)) u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd(cmd),
		.busy(busy), .done(done), .rsp(rsp)
	);

	always #5 clk = ~clk;

	// Shadow copy of the bank.
	logic        open_q[NSEM];
	logic [31:0] count_q[NSEM];
	int          depth_q[NSEM];
	logic [15:0] pids_q[NSEM][QDEP];

	csb_pkg::rsp_t pending_rsp[$];
	int            errors = 0;
	int            n_sent = 0;
	int            n_checked = 0;
	int            n_woken = 0;
	int            n_full = 0;

	function automatic csb_pkg::rsp_t semaphore_apply(csb_pkg::cmd_t c);
		csb_pkg::rsp_t r;
		int            s, pos;
		r = '0;
		s = int'(c.sem_index);
		if (c.operation == csb_pkg::OP_CREATE) begin
			if (open_q[s]) begin
				r.status = csb_pkg::ST_EXISTS;
			end else begin
				open_q[s] = 1'b1;
				count_q[s] = c.init_count;
				depth_q[s] = 0;
			end
			r.count_after = count_q[s];
		end else if (!open_q[s]) begin
			r.status = csb_pkg::ST_NOT_OPEN;
		end else begin
			case (c.operation)
				csb_pkg::OP_WAIT: begin
					if (count_q[s] != 0) begin
						count_q[s]--;
					end else if (depth_q[s] >= QDEP) begin
						r.status = csb_pkg::ST_FULL;
					end else begin
						pids_q[s][depth_q[s]] = c.proc_id;
						depth_q[s]++;
						r.status = csb_pkg::ST_BLOCKED;
					end
				end
				csb_pkg::OP_POST: begin
					if (count_q[s] != 0 || depth_q[s] == 0) begin
						if (count_q[s] != 32'hFFFF_FFFF) count_q[s]++;
					end else begin
						r.woken_valid = 1'b1;
						r.woken_pid = pids_q[s][0];
						for (int i = 0; i < depth_q[s] - 1; i++)
							pids_q[s][i] = pids_q[s][i+1];
						depth_q[s]--;
					end
				end
				default: begin
					pos = -1;
					for (int i = 0; i < depth_q[s]; i++)
						if (pos < 0 && pids_q[s][i] == c.proc_id) pos = i;
					if (pos < 0) begin
						r.status = csb_pkg::ST_NOT_FOUND;
					end else begin
						for (int i = pos; i < depth_q[s] - 1; i++)
							pids_q[s][i] = pids_q[s][i+1];
						depth_q[s]--;
					end
				end
			endcase
			r.count_after = count_q[s];
		end
		return r;
	endfunction

	// Issue one command beat; the check value, when given, must match the predictor.
	// start stays high after the beat until the next call or the caller drops it.
	task automatic issue_beat(csb_pkg::cmd_t c, bit has_fixed, csb_pkg::rsp_t fixed);
		csb_pkg::rsp_t r;
		while ($urandom_range(99) < 36 && n_sent > 40 && !(n_sent >= 300 && n_sent < 700))
		begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (busy) @(posedge clk);
		r = semaphore_apply(c);
		if (has_fixed && r !== fixed) begin
			errors++;
			if (errors <= 10)
				$display("predictor disagrees with table row %0d: %h vs %h",
					n_sent, fixed, r);
		end
		pending_rsp.push_back(r);
		if (r.woken_valid) n_woken++;
		if (r.status == csb_pkg::ST_FULL) n_full++;
		n_sent++;
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		csb_pkg::rsp_t e;
		if (arst_n && done) begin
			if (pending_rsp.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result beat %h", rsp);
			end else begin
				e = pending_rsp.pop_front();
				n_checked++;
				if (rsp.status !== e.status || rsp.woken_valid !== e.woken_valid ||
				    rsp.woken_pid !== e.woken_pid || rsp.count_after !== e.count_after) begin
					errors++;
					if (errors <= 10)
						$display({"mismatch: exp st=%0d wv=%0d pid=%h cnt=%h",
							" got st=%0d wv=%0d pid=%h cnt=%h"},
							e.status, e.woken_valid, e.woken_pid, e.count_after,
							rsp.status, rsp.woken_valid, rsp.woken_pid, rsp.count_after);
				end
			end
		end
	end

	typedef struct {
		csb_pkg::cmd_t c;
		bit            fixed;
		csb_pkg::rsp_t r;
	} row_t;

	function automatic row_t mk(logic [1:0] op, int s, int pid, logic [31:0] ic,
			bit fx, logic [2:0] st, logic wv, int wp, logic [31:0] ca);
		row_t w;
		w.c = '{operation: op, sem_index: s[2:0], proc_id: pid[15:0], init_count: ic};
		w.fixed = fx;
		w.r = '{status: st, woken_valid: wv, woken_pid: wp[15:0], count_after: ca};
		return w;
	endfunction

	initial begin
		#2_000_000;
		$display("timeout");
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		row_t          rows[$];
		csb_pkg::cmd_t c;
		int            s, k;
		for (int i = 0; i < NSEM; i++) begin
			open_q[i] = 0; count_q[i] = 0; depth_q[i] = 0;
		end
		rows = '{
			mk(csb_pkg::OP_WAIT,   0, 16'h1234, 0, 1, csb_pkg::ST_NOT_OPEN, 0, 0, 0),
			mk(csb_pkg::OP_POST,   7, 0, 0, 1, csb_pkg::ST_NOT_OPEN, 0, 0, 0),
			mk(csb_pkg::OP_REMOVE, 3, 5, 0, 1, csb_pkg::ST_NOT_OPEN, 0, 0, 0),
			mk(csb_pkg::OP_CREATE, 7, 0, 32'hFFFF_FFFE, 1, csb_pkg::ST_OK, 0, 0,
				32'hFFFF_FFFE),
			mk(csb_pkg::OP_CREATE, 7, 0, 5, 1, csb_pkg::ST_EXISTS, 0, 0, 32'hFFFF_FFFE),
			mk(csb_pkg::OP_POST,   7, 0, 0, 1, csb_pkg::ST_OK, 0, 0, 32'hFFFF_FFFF),
			mk(csb_pkg::OP_POST,   7, 0, 0, 1, csb_pkg::ST_OK, 0, 0, 32'hFFFF_FFFF),
			mk(csb_pkg::OP_CREATE, 0, 16'hFFFF, 0, 1, csb_pkg::ST_OK, 0, 0, 0),
			mk(csb_pkg::OP_REMOVE, 0, 7, 0, 1, csb_pkg::ST_NOT_FOUND, 0, 0, 0),
			mk(csb_pkg::OP_WAIT,   0, 16'hFFFF, 0, 1, csb_pkg::ST_BLOCKED, 0, 0, 0),
			mk(csb_pkg::OP_WAIT,   0, 16'h0000, 0, 0, csb_pkg::ST_OK, 0, 0, 0),
			mk(csb_pkg::OP_WAIT,   0, 16'hAAAA, 0, 0, csb_pkg::ST_OK, 0, 0, 0),
			mk(csb_pkg::OP_WAIT,   0, 16'hAAAA, 0, 0, csb_pkg::ST_OK, 0, 0, 0),
			mk(csb_pkg::OP_WAIT,   0, 16'h5555, 0, 0, csb_pkg::ST_OK, 0, 0, 0),
			mk(csb_pkg::OP_WAIT,   0, 16'h0001, 0, 0, csb_pkg::ST_OK, 0, 0, 0),
			mk(csb_pkg::OP_WAIT,   0, 16'h8000, 0, 0, csb_pkg::ST_OK, 0, 0, 0),
			mk(csb_pkg::OP_WAIT,   0, 16'h0042, 0, 0, csb_pkg::ST_OK, 0, 0, 0),
			mk(csb_pkg::OP_WAIT,   0, 16'h0099, 0, 1, csb_pkg::ST_FULL, 0, 0, 0),
			mk(csb_pkg::OP_REMOVE, 0, 16'hAAAA, 0, 0, csb_pkg::ST_OK, 0, 0, 0),
			mk(csb_pkg::OP_REMOVE, 0, 16'h0042, 0, 0, csb_pkg::ST_OK, 0, 0, 0),
			mk(csb_pkg::OP_REMOVE, 0, 16'hFFFF, 0, 0, csb_pkg::ST_OK, 0, 0, 0),
			mk(csb_pkg::OP_POST,   0, 0, 0, 1, csb_pkg::ST_OK, 1, 16'h0000, 0),
			mk(csb_pkg::OP_POST,   0, 0, 0, 1, csb_pkg::ST_OK, 1, 16'hAAAA, 0),
			mk(csb_pkg::OP_CREATE, 3, 0, 32'h8000_0001, 0, csb_pkg::ST_OK, 0, 0, 0),
			mk(csb_pkg::OP_WAIT,   3, 16'h0007, 0, 0, csb_pkg::ST_OK, 0, 0, 0)
		};
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (rows[i]) issue_beat(rows[i].c, rows[i].fixed, rows[i].r);

		for (int n = 0; n < NRAND; n++) begin
			// Hold off once until every outstanding beat has been checked.
			if (n == NRAND / 2) begin
				start <= 1'b0;
				@(negedge clk);
				while (pending_rsp.size() != 0) @(negedge clk);
			end
			c.sem_index = 3'($urandom_range(NSEM - 1));
			s = int'(c.sem_index);
			k = int'($urandom_range(99));
			c.init_count = ($urandom_range(3) == 0) ? $urandom : $urandom_range(3);
			if ($urandom_range(9) == 0) c.init_count = 32'hFFFF_FFFF - $urandom_range(1);
			c.proc_id = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(7));
			if (k < 8) begin
				c.operation = csb_pkg::OP_CREATE;
			end else if (k < 14 && open_q[s]) begin
				// Slots never close, so extra removes with arbitrary pids go here.
				c.operation = csb_pkg::OP_REMOVE;
			end else if (k < 50) begin
				c.operation = csb_pkg::OP_WAIT;
			end else if (k < 78) begin
				c.operation = csb_pkg::OP_POST;
			end else begin
				c.operation = csb_pkg::OP_REMOVE;
				if (depth_q[s] > 0 && $urandom_range(3) != 0)
					c.proc_id = pids_q[s][$urandom_range(depth_q[s] - 1)];
			end
			issue_beat(c, 1'b0, '0);
		end

		start <= 1'b0;
		k = 0;
		while (pending_rsp.size() != 0 && k < 1000) begin
			@(negedge clk);
			k++;
		end
		repeat (QDEP + 10) @(negedge clk);
		if (pending_rsp.size() != 0) errors++;
		$display("Sent %0d commands, checked %0d results, %0d wakeups, %0d queue-full.",
			n_sent, n_checked, n_woken, n_full);
		$display("Mismatches: %0d", errors);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: counting_semaphore_bank.f
rtl/csb_pkg.sv
rtl/csb_queue_mem.sv
rtl/counting_semaphore_bank.sv
bench/tb.sv
